// ----- src/two_tone_fsk_bit_receiver_defines.svh -----
// assertion macros for the fsk receiver
`ifndef TWO_TONE_FSK_BIT_RECEIVER_DEFINES_SVH
`define TWO_TONE_FSK_BIT_RECEIVER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FSK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define FSK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/ttfsk_pkg.sv -----
// package for the fsk receiver: constants, types, coefficient tables
package ttfsk_pkg;

  localparam int unsigned Sections    = 4;
  localparam int unsigned PeakWindow  = 18;
  localparam int unsigned CoefFrac    = 18;
  localparam int unsigned WinIdxW     = 5;
  localparam int unsigned SecIdxW     = 3;

  localparam logic [2:0] RegPeakThr   = 3'd0;
  localparam logic [2:0] RegNoiseLim  = 3'd1;
  localparam logic [2:0] RegFlukeWin  = 3'd2;
  localparam logic [2:0] RegTicksBit  = 3'd3;
  localparam logic [2:0] RegBitsFrame = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_STORE,
    ST_SCAN,
    ST_DECIDE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic signed [19:0] g;
    logic               neg;
    logic signed [20:0] a1;
    logic signed [20:0] a2;
  } coef_t;

  // filter set 0 = low tone, 1 = high tone
  function automatic coef_t coef_lookup(input logic hi, input logic [1:0] s);
    coef_t c;
    c = '0;
    case ({hi, s})
      3'd0: c = '{20'sd529,  1'b0, -21'sd483923, 21'sd258859};
      3'd1: c = '{20'sd514,  1'b0, -21'sd484958, 21'sd258902};
      3'd2: c = '{20'sd5976, 1'b1, -21'sd484972, 21'sd260766};
      3'd3: c = '{20'sd6013, 1'b1, -21'sd487423, 21'sd260808};
      3'd4: c = '{20'sd795,  1'b0, -21'sd465293, 21'sd258136};
      3'd5: c = '{20'sd774,  1'b0, -21'sd466806, 21'sd258186};
      3'd6: c = '{20'sd5932, 1'b1, -21'sd466309, 21'sd260461};
      3'd7: c = '{20'sd5953, 1'b1, -21'sd469912, 21'sd260512};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/two_tone_fsk_bit_receiver.sv -----
// two-tone fsk bit receiver: biquad cascades, peak windows, bit decision
//
// channel   dir  beat contents
// s_axis    in   tuser=action, tdata[11:0]=sample
// m_axis    out  one beat per tick, tdata[9:0] result fields
// cfg       in   cfg_addr_i register index, cfg_data_i value
//
// sample: load, then 2 filters x 4 sections, each a gain, a1 and a2 mac step, then store
// tick: scan of both peak windows, then a decision, then a clearing pass on fluke or frame end
// one shared 34x21 multiplier and one 52-bit accumulator do all filter work
// s_axis_tready is low while an item is in work or a result is not yet taken
// reset clears all state and windows; no clearing pass after reset
module two_tone_fsk_bit_receiver
  import ttfsk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[11:0], zero fill
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tone_low_seen, tone_high_seen, listening, frame_started, fluke,
  // bit_valid, bit_value, vote_sign[1:0], frame_done
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

`include "two_tone_fsk_bit_receiver_defines.svh"

  state_e state_q, state_d;

  // config
  logic [14:0] thr_q;
  logic [7:0]  noise_q, flukew_q, tpb_q;
  logic [5:0]  bpf_q;

  // filter state
  logic [11:0]        xh_q [2];
  logic signed [31:0] hl_q [Sections][2];
  logic signed [31:0] hh_q [Sections][2];
  logic signed [31:0] wl_q [PeakWindow];
  logic signed [31:0] wh_q [PeakWindow];
  logic [WinIdxW-1:0] widx_q;

  // sequencer
  logic               hi_q;      // which cascade
  logic [1:0]         sec_q;
  logic [1:0]         ph_q;      // mac phase
  logic signed [33:0] x0_q, x1_q, x2_q;
  logic signed [51:0] acc_q;
  logic signed [31:0] ylo_q;
  logic [WinIdxW-1:0] cnt_q;
  logic signed [31:0] pl_q, ph_pk_q;

  // control
  logic [7:0] tick_q, silent_q;
  logic [5:0] bitc_q;
  logic signed [8:0] vote_q;
  logic rx_q;

  logic        ovalid_q;
  logic [9:0]  odata_q;

  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, odata_q};

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  // shared multiplier operands
  coef_t c;
  logic signed [33:0] mix;
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] prod;
  logic signed [51:0] acc_n;
  logic signed [33:0] yfl;
  logic signed [31:0] ysat;
  always_comb begin
    c   = coef_lookup(hi_q, sec_q);
    mix = c.neg ? (x0_q - (x1_q <<< 1) + x2_q) : (x0_q + (x1_q <<< 1) + x2_q);
    case (ph_q)
      2'd0:    begin mul_a = mix; mul_b = 21'(c.g); end
      2'd1:    begin mul_a = 34'(hi_q ? hh_q[sec_q][0] : hl_q[sec_q][0]); mul_b = -c.a1; end
      default: begin mul_a = 34'(hi_q ? hh_q[sec_q][1] : hl_q[sec_q][1]); mul_b = -c.a2; end
    endcase
    prod  = 55'(mul_a) * 55'(mul_b);
    acc_n = acc_q + prod[51:0];
    yfl   = acc_n[51:CoefFrac];
    if (yfl > 34'sh7FFFFFFF)       ysat = 32'sh7FFFFFFF;
    else if (yfl < -34'sh80000000) ysat = 32'sh80000000;
    else                           ysat = yfl[31:0];
  end

  // tick decision
  logic lo, hi, started, fluke, bvalid, done;
  logic [7:0] tick_n, silent_n;
  logic [5:0] bitc_n;
  logic signed [9:0] vote_w;
  logic signed [8:0] vote_n, vote_snap;
  logic rx_n;
  always_comb begin
    lo = pl_q > $signed({17'd0, thr_q});
    hi = ph_pk_q > $signed({17'd0, thr_q});
    tick_n = tick_q; silent_n = silent_q; bitc_n = bitc_q; vote_n = vote_q; rx_n = rx_q;
    started = 1'b0; fluke = 1'b0; bvalid = 1'b0; done = 1'b0; vote_snap = '0;
    if (lo || hi) begin
      if (tick_n == 8'd0) begin
        bitc_n = '0; vote_n = '0; rx_n = 1'b1; silent_n = '0; started = 1'b1;
      end
      vote_w = 10'(vote_n) + 10'(hi) - 10'(lo);
      if (vote_w > 10'sd255)       vote_n = 9'sd255;
      else if (vote_w < -10'sd256) vote_n = -9'sd256;
      else                         vote_n = vote_w[8:0];
    end else begin
      vote_w = '0;
    end
    if (rx_n && bitc_n == 6'd0 && tick_n < flukew_q && !lo && !hi) begin
      if (silent_n != 8'd255) silent_n = silent_n + 8'd1;
      if (silent_n > noise_q) begin
        tick_n = '0; bitc_n = '0; vote_n = '0; rx_n = 1'b0; silent_n = '0; fluke = 1'b1;
      end
    end
    if (tick_n == tpb_q) begin
      bitc_n = bitc_n + 6'd1; tick_n = '0; bvalid = 1'b1; vote_snap = vote_n; vote_n = '0;
    end
    if (bitc_n == bpf_q) begin
      tick_n = '0; bitc_n = '0; vote_n = '0; rx_n = 1'b0; done = 1'b1;
    end
    if (rx_n) tick_n = tick_n + 8'd1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (acc_in) state_d = s_axis_tuser ? ST_SCAN : ST_MAC;
      ST_MAC:    if (ph_q == 2'd2 && sec_q == 2'(Sections - 1) && hi_q) state_d = ST_STORE;
      ST_STORE:  state_d = ST_IDLE;
      ST_SCAN:   if (cnt_q == WinIdxW'(PeakWindow - 1)) state_d = ST_DECIDE;
      ST_DECIDE: state_d = (fluke || done) ? ST_CLEAR : ST_IDLE;
      ST_CLEAR:  if (cnt_q == WinIdxW'(PeakWindow - 1)) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // input history at sample entry, needed again for the high cascade
  logic [11:0] x2_hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x2_hold_q <= '0;
    end else if (acc_in && !s_axis_tuser) begin
      x2_hold_q <= xh_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd500; noise_q <= 8'd10; flukew_q <= 8'd75; tpb_q <= 8'd100; bpf_q <= 6'd13;
      xh_q <= '{default: '0}; hl_q <= '{default: '{default: '0}};
      hh_q <= '{default: '{default: '0}};
      wl_q <= '{default: '0}; wh_q <= '{default: '0};
      widx_q <= '0; hi_q <= 1'b0; sec_q <= '0; ph_q <= '0; cnt_q <= '0;
      x0_q <= '0; x1_q <= '0; x2_q <= '0; acc_q <= '0; ylo_q <= '0;
      pl_q <= '0; ph_pk_q <= '0;
      tick_q <= '0; silent_q <= '0; bitc_q <= '0; vote_q <= '0; rx_q <= 1'b0;
      ovalid_q <= 1'b0; odata_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          RegPeakThr:   thr_q    <= cfg_data_i[14:0];
          RegNoiseLim:  noise_q  <= cfg_data_i[7:0];
          RegFlukeWin:  flukew_q <= cfg_data_i[7:0];
          RegTicksBit:  tpb_q    <= cfg_data_i[7:0];
          RegBitsFrame: bpf_q    <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0; pl_q <= '0; ph_pk_q <= '0;
          if (acc_in && !s_axis_tuser) begin
            x0_q <= 34'(s_axis_tdata[11:0]); x1_q <= 34'(xh_q[0]); x2_q <= 34'(xh_q[1]);
            xh_q[1] <= xh_q[0]; xh_q[0] <= s_axis_tdata[11:0];
            hi_q <= 1'b0; sec_q <= '0; ph_q <= '0; acc_q <= '0;
          end
        end
        ST_MAC: begin
          if (ph_q != 2'd2) begin
            acc_q <= acc_n; ph_q <= ph_q + 2'd1;
          end else begin
            acc_q <= '0; ph_q <= '0;
            if (hi_q) begin
              hh_q[sec_q][1] <= hh_q[sec_q][0]; hh_q[sec_q][0] <= ysat;
            end else begin
              hl_q[sec_q][1] <= hl_q[sec_q][0]; hl_q[sec_q][0] <= ysat;
            end
            if (sec_q == 2'(Sections - 1) && !hi_q) begin
              // low cascade done, restart from the sample for the high cascade
              sec_q <= '0; ylo_q <= ysat; hi_q <= 1'b1;
              x0_q <= 34'(xh_q[0]); x1_q <= 34'(xh_q[1]);
              x2_q <= 34'(x2_hold_q);
            end else begin
              x0_q <= 34'(ysat);
              if (hi_q) begin
                x1_q <= 34'(hh_q[sec_q][0]); x2_q <= 34'(hh_q[sec_q][1]);
              end else begin
                x1_q <= 34'(hl_q[sec_q][0]); x2_q <= 34'(hl_q[sec_q][1]);
              end
              sec_q <= (sec_q == 2'(Sections - 1)) ? 2'd0 : sec_q + 2'd1;
            end
          end
        end
        ST_STORE: begin
          wl_q[widx_q] <= ylo_q; wh_q[widx_q] <= x0_q[31:0];
          widx_q <= (widx_q == WinIdxW'(PeakWindow - 1)) ? '0 : widx_q + 1'b1;
        end
        ST_SCAN: begin
          if (wl_q[cnt_q] > pl_q)    pl_q    <= wl_q[cnt_q];
          if (wh_q[cnt_q] > ph_pk_q) ph_pk_q <= wh_q[cnt_q];
          cnt_q <= cnt_q + 1'b1;
        end
        ST_DECIDE: begin
          tick_q <= tick_n; silent_q <= silent_n; bitc_q <= bitc_n;
          vote_q <= vote_n; rx_q <= rx_n; cnt_q <= '0;
          ovalid_q <= 1'b1;
          odata_q <= {done, (vote_snap > 0) ? 2'b01 : ((vote_snap < 0) ? 2'b11 : 2'b00),
                      bvalid && (vote_snap > 0), bvalid, fluke, started, rx_n, hi, lo};
        end
        ST_CLEAR: begin
          wl_q[cnt_q] <= '0; wh_q[cnt_q] <= '0;
          xh_q <= '{default: '0}; hl_q <= '{default: '{default: '0}};
          hh_q <= '{default: '{default: '0}};
          cnt_q <= cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `FSK_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready)
  `FSK_ASSERT_NEXT(a_decide_gives_beat, state_q == ST_DECIDE, m_axis_tvalid)
  `FSK_ASSERT_IMP(a_phase_range, state_q == ST_MAC, ph_q != 2'd3)
  `FSK_ASSERT_IMP(a_widx_range, 1'b1, widx_q < WinIdxW'(PeakWindow))

endmodule
